/* rtl/core/vtn_pkg.sv */
`default_nettype none

package vtn_pkg;

  localparam int unsigned NumVox    = 27;
  localparam int unsigned CentreIdx = 13;
  localparam int unsigned NumFace   = 6;

  typedef logic [4:0] flabel_t;
  typedef logic [5:0] bkey_t;

  // All-ones marks a voxel outside the set being labeled
  localparam flabel_t FNone = 5'h1f;
  localparam bkey_t   BNone = 6'h3f;

  typedef enum logic [0:0] {
    StIdle,
    StRun
  } state_e;

  typedef enum logic [1:0] {
    RegForeLow,
    RegForeHigh,
    RegBackLow,
    RegBackHigh
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic step;
  } cell_ctl_t;

  typedef struct packed {
    logic changed;
    logic fore_root;
    logic back_root;
  } cell_stat_t;

  function automatic int unsigned axis_off(int unsigned c);
    return (c == 1) ? 0 : 1;
  endfunction

  // City-block distance of a voxel from the centre
  function automatic int unsigned city_dist(int unsigned k);
    return axis_off(k % 3) + axis_off((k / 3) % 3) + axis_off(k / 9);
  endfunction

  function automatic bit is_face(int unsigned k);
    return city_dist(k) == 1;
  endfunction

  function automatic bit in_n18(int unsigned k);
    return (city_dist(k) >= 1) && (city_dist(k) <= 2);
  endfunction

  function automatic bit in_n26(int unsigned k);
    return city_dist(k) >= 1;
  endfunction

  function automatic flabel_t fmin(flabel_t a, flabel_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/vtn_cell.sv */
`default_nettype none

module vtn_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire vtn_pkg::cell_ctl_t    ctl_i,
  input  wire logic                  fore_mask_i,
  input  wire logic                  back_mask_i,
  input  wire vtn_pkg::flabel_t      fore_nbr_i,
  input  wire vtn_pkg::bkey_t [5:0]  back_nbr_i,
  output vtn_pkg::flabel_t           fore_lbl_o,
  output vtn_pkg::bkey_t             back_lbl_o,
  output vtn_pkg::cell_stat_t        stat_o
);
  import vtn_pkg::*;

  localparam bit      Face = is_face(Idx);
  localparam flabel_t OwnF = flabel_t'(Idx);
  localparam bkey_t   OwnB = {~Face, OwnF};

  flabel_t fore_q, fore_d;
  bkey_t   back_q, back_d;
  bkey_t   back_best;
  logic    fore_lower, back_lower;

  // Start empty; the controller loads a cube before each run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q <= FNone;
      back_q <= BNone;
    end else begin
      fore_q <= fore_d;
      back_q <= back_d;
    end
  end

  always_comb begin
    back_best = back_q;
    for (int n = 0; n < 6; n++) begin
      if (back_nbr_i[n] < back_best) begin
        back_best = back_nbr_i[n];
      end
    end
  end

  // Voxels outside the set keep the none label and never pick up a neighbor
  assign fore_lower = (fore_q != FNone) && (fore_nbr_i < fore_q);
  assign back_lower = (back_q != BNone) && (back_best < back_q);

  always_comb begin
    fore_d = fore_q;
    back_d = back_q;
    if (ctl_i.load) begin
      fore_d = fore_mask_i ? OwnF : FNone;
      back_d = back_mask_i ? OwnB : BNone;
    end else if (ctl_i.step) begin
      if (fore_lower) begin
        fore_d = fore_nbr_i;
      end
      if (back_lower) begin
        back_d = back_best;
      end
    end
  end

  assign fore_lbl_o       = fore_q;
  assign back_lbl_o       = back_q;
  assign stat_o.changed   = fore_lower || back_lower;
  assign stat_o.fore_root = (fore_q == OwnF);
  assign stat_o.back_root = Face && (back_q == OwnB);

endmodule

`default_nettype wire

/* rtl/core/voxel_topological_numbers.sv */
// On input accept the cells load the cube and the controller enters its run state; the
// labels then propagate until no cell label changes, and once the output is free the
// counts are registered with output valid. An empty centre loads no labels to propagate.
// A new cube is taken only back in idle; a result waiting on out_stall_i holds the run.
// Reset clears the controller, cell labels and output valid and sets all bounds to 1.
`default_nettype none

module voxel_topological_numbers (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [26:0] cube_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [3:0]  fore_count_o,
  output logic      [2:0]  back_count_o,
  output logic      [7:0]  packed_counts_o,
  output logic             hit_o
);
  import vtn_pkg::*;

  // Configuration
  logic [3:0] fore_low_q, fore_high_q;
  logic [2:0] back_low_q, back_high_q;
  logic       cfg_wr;
  cfg_reg_e   cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_low_q  <= 4'd1;
      fore_high_q <= 4'd1;
      back_low_q  <= 3'd1;
      back_high_q <= 3'd1;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        RegForeLow:  fore_low_q  <= pwdata[3:0];
        RegForeHigh: fore_high_q <= pwdata[3:0];
        RegBackLow:  back_low_q  <= pwdata[2:0];
        RegBackHigh: back_high_q <= pwdata[2:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegForeLow:  prdata = {28'd0, fore_low_q};
      RegForeHigh: prdata = {28'd0, fore_high_q};
      RegBackLow:  prdata = {29'd0, back_low_q};
      RegBackHigh: prdata = {29'd0, back_high_q};
    endcase
  end

  // Control
  state_e     state_q, state_d;
  cell_ctl_t  ctl;
  logic       in_accept, out_free, finish;
  logic       centre_q;
  logic       any_changed;

  flabel_t            fv [NumVox];
  bkey_t              bv [NumVox];
  cell_stat_t         stat [NumVox];
  logic [NumVox-1:0]  changed_vec, fore_roots;
  logic [NumFace-1:0] back_roots;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_o || !out_stall_i;
  assign any_changed = |changed_vec;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_accept) state_d = StRun;
      StRun:  if (!any_changed && out_free) state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != StIdle);
    ctl.load   = in_accept;
    ctl.step   = (state_q == StRun);
    finish     = (state_q == StRun) && !any_changed && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      centre_q <= cube_bits_i[CentreIdx];
    end
  end

  // Cell row: one cell per voxel, labels flow between neighbors every cycle of the run state
  for (genvar k = 0; k < NumVox; k++) begin : g_vox
    localparam int unsigned X = k % 3;
    localparam int unsigned Y = (k / 3) % 3;
    localparam int unsigned Z = k / 9;

    flabel_t   xlo, xhi, ylo, yhi, zlo, zhi;
    flabel_t   mx, my, box;
    bkey_t [5:0] bn;
    logic      fmask, bmask;

    // Fore 26-adjacency as a separable 3x3x3 box minimum, x then y then z; back 6-adjacency
    if (X > 0) begin : g_xlo
      assign xlo = fv[k-1];
      assign bn[0] = bv[k-1];
    end else begin : g_xlo_n
      assign xlo = FNone;
      assign bn[0] = BNone;
    end
    if (X < 2) begin : g_xhi
      assign xhi = fv[k+1];
      assign bn[1] = bv[k+1];
    end else begin : g_xhi_n
      assign xhi = FNone;
      assign bn[1] = BNone;
    end
    assign mx = fmin(fv[k], fmin(xlo, xhi));

    if (Y > 0) begin : g_ylo
      assign ylo = g_vox[k-3].mx;
      assign bn[2] = bv[k-3];
    end else begin : g_ylo_n
      assign ylo = FNone;
      assign bn[2] = BNone;
    end
    if (Y < 2) begin : g_yhi
      assign yhi = g_vox[k+3].mx;
      assign bn[3] = bv[k+3];
    end else begin : g_yhi_n
      assign yhi = FNone;
      assign bn[3] = BNone;
    end
    assign my = fmin(mx, fmin(ylo, yhi));

    if (Z > 0) begin : g_zlo
      assign zlo = g_vox[k-9].my;
      assign bn[4] = bv[k-9];
    end else begin : g_zlo_n
      assign zlo = FNone;
      assign bn[4] = BNone;
    end
    if (Z < 2) begin : g_zhi
      assign zhi = g_vox[k+9].my;
      assign bn[5] = bv[k+9];
    end else begin : g_zhi_n
      assign zhi = FNone;
      assign bn[5] = BNone;
    end
    assign box = fmin(my, fmin(zlo, zhi));

    assign fmask = cube_bits_i[CentreIdx] && in_n26(k) && cube_bits_i[k];
    assign bmask = cube_bits_i[CentreIdx] && in_n18(k) && !cube_bits_i[k];

    vtn_cell #(
      .Idx (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .fore_mask_i (fmask),
      .back_mask_i (bmask),
      .fore_nbr_i  (box),
      .back_nbr_i  (bn),
      .fore_lbl_o  (fv[k]),
      .back_lbl_o  (bv[k]),
      .stat_o      (stat[k])
    );

    assign changed_vec[k] = stat[k].changed;
    assign fore_roots[k]  = stat[k].fore_root;
  end

  // Only face voxels can be background roots
  assign back_roots = {stat[22].back_root, stat[16].back_root, stat[14].back_root,
                       stat[12].back_root, stat[10].back_root, stat[4].back_root};

  // Result
  logic [3:0] fore_cnt;
  logic [2:0] back_cnt;
  logic       hit_d;

  assign fore_cnt = 4'($countones(fore_roots));
  assign back_cnt = 3'($countones(back_roots));
  assign hit_d    = centre_q &&
                    (fore_low_q <= fore_cnt) && (fore_cnt <= fore_high_q) &&
                    (back_low_q <= back_cnt) && (back_cnt <= back_high_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (finish) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      fore_count_o    <= fore_cnt;
      back_count_o    <= back_cnt;
      packed_counts_o <= {1'b0, back_cnt, fore_cnt};
      hit_o           <= hit_d;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_voxel_topological_numbers.sv */
`default_nettype none

module tb_voxel_topological_numbers;
  import vtn_pkg::*;

  localparam int unsigned Mid          = CentreIdx;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned ReportMax    = 10;

  typedef struct packed {
    logic [26:0] cube;
    logic [3:0]  fore;
    logic [2:0]  back;
    logic [7:0]  nibbles;
    logic        hit;
  } counts_t;

  typedef struct packed {
    logic    typed;
    counts_t item;
  } probe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [26:0] cube_bits_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  fore_count_o;
  logic [2:0]  back_count_o;
  logic [7:0]  packed_counts_o;
  logic        hit_o;

  // 26- and 6-adjacency of every voxel inside the cube
  logic [26:0] reach_any  [27];
  logic [26:0] reach_face [27];
  logic [26:0] face_ring;
  logic [26:0] edge_ring;
  logic [26:0] corner_ring;
  logic [26:0] mid_bit;

  logic [3:0]  fore_lo;
  logic [3:0]  fore_hi;
  logic [2:0]  back_lo;
  logic [2:0]  back_hi;

  counts_t     expected_counts [$];
  probe_t      probes [$];
  counts_t     want;
  int unsigned errors;
  int unsigned rx_left;
  int unsigned quiet_cycles;
  bit          no_idle;

  voxel_topological_numbers dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cube_bits_i    (cube_bits_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fore_count_o   (fore_count_o),
    .back_count_o   (back_count_o),
    .packed_counts_o(packed_counts_o),
    .hit_o          (hit_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned ring_of(int unsigned k);
    int unsigned d;
    d = 0;
    if (k % 3 != 1) d++;
    if ((k / 3) % 3 != 1) d++;
    if (k / 9 != 1) d++;
    return d;
  endfunction

  function automatic logic [26:0] ring_mask(int unsigned d);
    logic [26:0] m;
    int unsigned k;
    m = '0;
    for (k = 0; k < 27; k++) if (ring_of(k) == d) m[k] = 1'b1;
    return m;
  endfunction

  function automatic logic [26:0] near(int k, bit diag);
    logic [26:0] m;
    int j;
    int dx;
    int dy;
    int dz;
    m = '0;
    for (j = 0; j < 27; j++) begin
      dx = k % 3 - j % 3;
      dy = (k / 3) % 3 - (j / 3) % 3;
      dz = k / 9 - j / 9;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      if (j != k && dx <= 1 && dy <= 1 && dz <= 1 && (diag || dx + dy + dz == 1))
        m[j] = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [26:0] flood(logic [26:0] seed, logic [26:0] mask, bit diag);
    logic [26:0] comp;
    logic [26:0] grown;
    int i;
    grown = seed;
    do begin
      comp = grown;
      for (i = 0; i < 27; i++)
        if (comp[i]) grown |= (diag ? reach_any[i] : reach_face[i]) & mask;
    end while (grown != comp);
    return comp;
  endfunction

  // Count the components of mask that hold at least one seed voxel
  function automatic int unsigned tally(logic [26:0] mask, logic [26:0] seeds, bit diag);
    int unsigned n;
    int i;
    logic [26:0] b;
    n = 0;
    for (i = 0; i < 27; i++) begin
      b = 27'd1 << i;
      if ((seeds & mask & b) != '0) begin
        mask &= ~flood(b, mask, diag);
        n++;
      end
    end
    return n;
  endfunction

  function automatic counts_t predict_counts(logic [26:0] cube);
    counts_t r;
    logic [26:0] n26;
    logic [26:0] n18;
    r = '0;
    r.cube = cube;
    if (cube[Mid]) begin
      n26 = face_ring | edge_ring | corner_ring;
      n18 = face_ring | edge_ring;
      r.fore = 4'(tally(cube & n26, n26, 1'b1));
      r.back = 3'(tally(~cube & n18, face_ring, 1'b0));
      r.hit  = fore_lo <= r.fore && r.fore <= fore_hi &&
               back_lo <= r.back && r.back <= back_hi;
    end
    r.nibbles = {1'b0, r.back, r.fore};
    return r;
  endfunction

  function automatic probe_t row(logic [26:0] cube, logic typed, logic [3:0] f,
                                 logic [2:0] b, logic [7:0] n, logic h);
    probe_t p;
    p.typed        = typed;
    p.item.cube    = cube;
    p.item.fore    = f;
    p.item.back    = b;
    p.item.nibbles = n;
    p.item.hit     = h;
    return p;
  endfunction

  function automatic logic [26:0] random_cube();
    logic [26:0] c;
    int unsigned kind;
    int unsigned pct;
    int k;
    kind = $urandom_range(0, 9);
    c = '0;
    if (kind < 2) begin
      c = 27'($urandom());
    end else begin
      if (kind < 5) pct = $urandom_range(10, 35);
      else if (kind < 8) pct = $urandom_range(60, 90);
      else pct = $urandom_range(0, 30);
      for (k = 0; k < 27; k++) c[k] = $urandom_range(0, 99) < pct;
      // edge skeleton with a few flips gives many background pieces
      if (kind == 9) c ^= edge_ring;
      c[Mid] = 1'b1;
    end
    return c;
  endfunction

  task automatic write_reg(cfg_reg_e r, logic [3:0] val);
    logic [31:0] junk;
    junk = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    case (r)
      RegForeLow: begin
        pwdata  <= {junk[31:4], val};
        fore_lo = val;
      end
      RegForeHigh: begin
        pwdata  <= {junk[31:4], val};
        fore_hi = val;
      end
      RegBackLow: begin
        pwdata  <= {junk[31:3], val[2:0]};
        back_lo = val[2:0];
      end
      RegBackHigh: begin
        pwdata  <= {junk[31:3], val[2:0]};
        back_hi = val[2:0];
      end
      default: ;
    endcase
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [3:0] fl, logic [3:0] fh, logic [2:0] bl, logic [2:0] bh);
    write_reg(RegForeLow, fl);
    write_reg(RegForeHigh, fh);
    write_reg(RegBackLow, {1'b0, bl});
    write_reg(RegBackHigh, {1'b0, bh});
  endtask

  task automatic send(probe_t p);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cube_bits_i <= p.item.cube;
    do @(posedge clk_i); while (in_stall_o);
    expected_counts.push_back(p.typed ? p.item : predict_counts(p.item.cube));
  endtask

  // Hold off until every request has been answered and the cell row is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_counts.size() == 0) begin
          errors++;
          if (errors <= ReportMax)
            $display("unexpected result: fore %0d back %0d nibbles %02h hit %0d",
                     fore_count_o, back_count_o, packed_counts_o, hit_o);
        end else begin
          want = expected_counts.pop_front();
          if (fore_count_o !== want.fore || back_count_o !== want.back ||
              packed_counts_o !== want.nibbles || hit_o !== want.hit) begin
            errors++;
            if (errors <= ReportMax)
              $display("cube %07h: expected fore %0d back %0d nibbles %02h hit %0d, got fore %0d back %0d nibbles %02h hit %0d",
                       want.cube, want.fore, want.back, want.nibbles, want.hit,
                       fore_count_o, back_count_o, packed_counts_o, hit_o);
          end
        end
        rx_left = no_idle ? 0 : $urandom_range(0, 8);
      end else if (rx_left != 0) begin
        rx_left = rx_left - 1;
      end
      out_stall_i <= (rx_left != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pwrite && pready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
        $display("tb_voxel_topological_numbers NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int k;
    int unsigned ph;
    int unsigned n;
    logic [3:0] lo;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    cube_bits_i  = '0;
    out_stall_i  = 1'b0;
    errors       = 0;
    rx_left      = 0;
    quiet_cycles = 0;
    no_idle      = 1'b0;
    fore_lo      = 4'd1;
    fore_hi      = 4'd1;
    back_lo      = 3'd1;
    back_hi      = 3'd1;

    for (k = 0; k < 27; k++) begin
      reach_any[k]  = near(k, 1'b1);
      reach_face[k] = near(k, 1'b0);
    end
    face_ring   = ring_mask(1);
    edge_ring   = ring_mask(2);
    corner_ring = ring_mask(3);
    mid_bit     = 27'd1 << Mid;

    // empty centre, full cube, lone centre, full cube with empty centre
    probes.push_back(row(27'h0, 1'b1, 4'd0, 3'd0, 8'h00, 1'b0));
    probes.push_back(row(27'h7FFFFFF, 1'b1, 4'd1, 3'd0, 8'h01, 1'b0));
    probes.push_back(row(mid_bit, 1'b1, 4'd0, 3'd1, 8'h10, 1'b0));
    probes.push_back(row(27'h7FFDFFF, 1'b1, 4'd0, 3'd0, 8'h00, 1'b0));
    // one face neighbor: a simple point, which hits at the reset bounds
    probes.push_back(row(mid_bit | 27'h10, 1'b1, 4'd1, 3'd1, 8'h11, 1'b1));
    probes.push_back(row(mid_bit | face_ring, 1'b1, 4'd1, 3'd0, 8'h01, 1'b0));
    // isolated corners give the largest foreground count
    probes.push_back(row(mid_bit | corner_ring, 1'b1, 4'd8, 3'd1, 8'h18, 1'b0));
    // edge skeleton cuts every face voxel off: largest background count
    probes.push_back(row(mid_bit | edge_ring, 1'b1, 4'd1, 3'd6, 8'h61, 1'b0));
    probes.push_back(row(mid_bit | edge_ring | corner_ring, 1'b1, 4'd1, 3'd6, 8'h61, 1'b0));
    probes.push_back(row(mid_bit | corner_ring | face_ring, 1'b0, 4'd0, 3'd0, 8'h00, 1'b0));
    probes.push_back(row(mid_bit | (edge_ring & ~27'h2), 1'b0, 4'd0, 3'd0, 8'h00, 1'b0));
    probes.push_back(row(mid_bit | 27'h4000001, 1'b0, 4'd0, 3'd0, 8'h00, 1'b0));
    probes.push_back(row(27'h7FFFFFF & ~face_ring, 1'b0, 4'd0, 3'd0, 8'h00, 1'b0));
    probes.push_back(row(mid_bit | (edge_ring & 27'h1FF), 1'b0, 4'd0, 3'd0, 8'h00, 1'b0));
    probes.push_back(row(mid_bit | 27'h5555555, 1'b0, 4'd0, 3'd0, 8'h00, 1'b0));
    probes.push_back(row(mid_bit | 27'h2AAAAAA, 1'b0, 4'd0, 3'd0, 8'h00, 1'b0));
    for (k = 0; k < 6; k++)
      probes.push_back(row(random_cube(), 1'b0, 4'd0, 3'd0, 8'h00, 1'b0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) send(probes[i]);
    drain();

    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: configure(4'd0, 4'd15, 3'd0, 3'd7);
        1: configure(4'd15, 4'd0, 3'd7, 3'd0);
        2: configure(4'd0, 4'd8, 3'd0, 3'd6);
        3: configure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        4: begin
          lo = 4'($urandom_range(0, 8));
          configure(lo, lo + 4'($urandom_range(0, 2)), 3'($urandom_range(0, 3)),
                    3'($urandom_range(1, 6)));
        end
        default: configure(4'd2, 4'd8, 3'd2, 3'd6);
      endcase
      no_idle = (ph == 1 || ph == 4);
      for (n = 0; n < PhaseItems; n++) begin
        send(row(random_cube(), 1'b0, 4'd0, 3'd0, 8'h00, 1'b0));
        if (ph == 2 && n % 25 == 24) drain();
      end
      drain();
    end

    if (errors == 0 && expected_counts.size() == 0)
      $display("tb_voxel_topological_numbers OK");
    else
      $display("tb_voxel_topological_numbers NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/vtn_pkg.sv
rtl/core/vtn_cell.sv
rtl/core/voxel_topological_numbers.sv
tb/tb_voxel_topological_numbers.sv
